// ===== sv/mmp_pkg.sv =====
// Shared types, constants and helpers for the 2x2 modular matrix power block.
package mmp_pkg;

    localparam int unsigned ELEM_W = 30;
    localparam int unsigned POW_W  = 63;

    typedef logic [ELEM_W-1:0] t_elem;

    // Prime modulus and Barrett constant floor(2^60 / P).
    localparam t_elem       MOD_P   = 30'd1000000007;
    localparam logic [61:0] MU_WIDE = 62'h1000_0000_0000_0000 / 62'd1000000007;
    localparam logic [30:0] MU      = MU_WIDE[30:0];

    typedef struct packed {
        t_elem              base_r0c0;
        t_elem              base_r0c1;
        t_elem              base_r1c0;
        t_elem              base_r1c1;
        logic [POW_W-1:0]   power;
    } t_in;

    typedef struct packed {
        t_elem res_r0c0;
        t_elem res_r0c1;
        t_elem res_r1c0;
        t_elem res_r1c1;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_COMMIT,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PROD,
        M_QUOT,
        M_QP,
        M_SUB,
        M_FIX
    } t_mul_phase;

    // Subtract the modulus once when the value reaches it.
    function automatic logic [31:0] sub_p_once(input logic [31:0] v);
        logic [31:0] p_ext;
        p_ext = {2'b00, MOD_P};
        return (v >= p_ext) ? (v - p_ext) : v;
    endfunction

endpackage

// ===== sv/mmp_modmul.sv =====
// Multi-cycle modular multiplier: one 31x31 multiplier reused for product and Barrett steps.
module mmp_modmul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mmp_pkg::t_elem i_a,
    input  mmp_pkg::t_elem i_b,
    output logic           o_done,
    output mmp_pkg::t_elem o_res
);

    mmp_pkg::t_mul_phase r_phase, n_phase;

    mmp_pkg::t_elem r_a, r_b;
    logic [59:0]    r_x;
    logic [61:0]    r_m;
    logic [31:0]    r_r;

    logic [30:0] mul_x, mul_y;
    logic [61:0] mul_p;
    logic [31:0] diff;
    logic [31:0] fixed;

    assign mul_p = 62'(mul_x) * 62'(mul_y);
    assign diff  = r_x[31:0] - r_m[31:0];
    assign fixed = mmp_pkg::sub_p_once(r_r);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            mmp_pkg::M_IDLE: if (i_start) n_phase = mmp_pkg::M_PROD;
            mmp_pkg::M_PROD: n_phase = mmp_pkg::M_QUOT;
            mmp_pkg::M_QUOT: n_phase = mmp_pkg::M_QP;
            mmp_pkg::M_QP:   n_phase = mmp_pkg::M_SUB;
            mmp_pkg::M_SUB:  n_phase = mmp_pkg::M_FIX;
            mmp_pkg::M_FIX:  n_phase = mmp_pkg::M_IDLE;
            default:         n_phase = mmp_pkg::M_IDLE;
        endcase
    end

    // Steer the shared multiplier by phase.
    always_comb begin
        mul_x  = {1'b0, r_a};
        mul_y  = {1'b0, r_b};
        o_done = 1'b0;
        unique case (r_phase)
            mmp_pkg::M_QUOT: begin
                mul_x = r_x[59:29];
                mul_y = mmp_pkg::MU;
            end
            mmp_pkg::M_QP: begin
                mul_x = r_m[61:31];
                mul_y = {1'b0, mmp_pkg::MOD_P};
            end
            mmp_pkg::M_FIX: o_done = 1'b1;
            default: ;
        endcase
    end

    assign o_res = fixed[29:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mmp_pkg::M_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == mmp_pkg::M_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_phase == mmp_pkg::M_PROD) r_x <= mul_p[59:0];
        if (r_phase == mmp_pkg::M_QUOT || r_phase == mmp_pkg::M_QP) r_m <= mul_p;
        // remainder before correction is below 3P, so low 32 bits are exact
        if (r_phase == mmp_pkg::M_SUB) r_r <= mmp_pkg::sub_p_once(diff);
    end

endmodule

// ===== sv/modular_matrix_power_2x2.sv =====
// Top level: square-and-multiply sequencer over 2x2 matrices modulo 1000000007.
//
//  channel   ports                      handshake
//  request   i_start, i_in (t_in)       transfer when i_start && !o_busy
//  result    o_valid, o_res (t_out)     one-cycle strobe, always taken
//
// Each modular term runs on the shared multiplier; a matrix product is 8 terms
// plus one commit state, and an item takes one product per bit of the power plus
// one per set bit, less one; a zero power goes straight to the result. o_busy
// stays high from transfer to the result strobe.
// Reset is synchronous and active low and returns the sequencer to idle.
module modular_matrix_power_2x2 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mmp_pkg::t_in  i_in,
    output logic          o_busy,
    output logic          o_valid,
    output mmp_pkg::t_out o_res
);

    mmp_pkg::t_state r_state, n_state;

    mmp_pkg::t_elem r_base [4];
    mmp_pkg::t_elem r_acc  [4];
    mmp_pkg::t_elem r_tmp  [4];
    mmp_pkg::t_elem r_sum;
    logic [mmp_pkg::POW_W-1:0] r_pow;
    logic       r_sq;
    logic [1:0] r_ent;
    logic       r_k;

    logic           mm_start, mm_done;
    mmp_pkg::t_elem mm_a, mm_b, mm_res;
    logic [1:0]     a_idx, b_idx;
    logic [31:0]    sum_w, sum_red;
    logic           accept;
    logic           last_term;

    logic [31:0] in_red [4];

    assign in_red[0] = mmp_pkg::sub_p_once({2'b00, i_in.base_r0c0});
    assign in_red[1] = mmp_pkg::sub_p_once({2'b00, i_in.base_r0c1});
    assign in_red[2] = mmp_pkg::sub_p_once({2'b00, i_in.base_r1c0});
    assign in_red[3] = mmp_pkg::sub_p_once({2'b00, i_in.base_r1c1});

    assign a_idx = {r_ent[1], r_k};
    assign b_idx = {r_k, r_ent[0]};
    assign mm_a  = r_sq ? r_base[a_idx] : r_acc[a_idx];
    assign mm_b  = r_base[b_idx];

    assign sum_w     = {2'b00, r_sum} + {2'b00, mm_res};
    assign sum_red   = mmp_pkg::sub_p_once(sum_w);
    assign accept    = i_start && (r_state == mmp_pkg::ST_IDLE);
    assign last_term = r_k && (r_ent == 2'd3);

    mmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_in.power == '0) ? mmp_pkg::ST_OUT : mmp_pkg::ST_ISSUE;
                end
            end
            mmp_pkg::ST_ISSUE: n_state = mmp_pkg::ST_WAIT;
            mmp_pkg::ST_WAIT: begin
                if (mm_done) n_state = last_term ? mmp_pkg::ST_COMMIT : mmp_pkg::ST_ISSUE;
            end
            mmp_pkg::ST_COMMIT: begin
                if (r_pow[mmp_pkg::POW_W-1:1] == '0) n_state = mmp_pkg::ST_OUT;
                else n_state = mmp_pkg::ST_ISSUE;
            end
            mmp_pkg::ST_OUT:  n_state = mmp_pkg::ST_IDLE;
            default:          n_state = mmp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy   = 1'b1;
        o_valid  = 1'b0;
        mm_start = 1'b0;
        unique case (r_state)
            mmp_pkg::ST_IDLE:  o_busy   = 1'b0;
            mmp_pkg::ST_ISSUE: mm_start = 1'b1;
            mmp_pkg::ST_OUT:   o_valid  = 1'b1;
            default: ;
        endcase
    end

    assign o_res.res_r0c0 = r_acc[0];
    assign o_res.res_r0c1 = r_acc[1];
    assign o_res.res_r1c0 = r_acc[2];
    assign o_res.res_r1c1 = r_acc[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int e = 0; e < 4; e++) begin
                r_base[e] <= in_red[e][29:0];
            end
            r_acc[0] <= mmp_pkg::t_elem'(1);
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_acc[3] <= mmp_pkg::t_elem'(1);
            r_pow    <= i_in.power;
            r_sq     <= ~i_in.power[0];
            r_ent    <= '0;
            r_k      <= 1'b0;
        end
        if (r_state == mmp_pkg::ST_WAIT && mm_done) begin
            if (!r_k) begin
                r_sum <= mm_res;
                r_k   <= 1'b1;
            end else begin
                r_tmp[r_ent] <= sum_red[29:0];
                r_k          <= 1'b0;
                r_ent        <= r_ent + 2'd1;
            end
        end
        if (r_state == mmp_pkg::ST_COMMIT) begin
            for (int e = 0; e < 4; e++) begin
                if (r_sq) r_base[e] <= r_tmp[e];
                else      r_acc[e]  <= r_tmp[e];
            end
            // after a multiply the same bit still needs its square; after a square, advance
            if (r_sq) begin
                r_pow <= r_pow >> 1;
                r_sq  <= ~r_pow[1];
            end else begin
                r_sq  <= 1'b1;
            end
        end
    end

endmodule

// ===== tb/sv/modular_matrix_power_2x2_checker.sv =====
// Checker for the 2x2 modular matrix power block: predicts each power and compares results.
module modular_matrix_power_2x2_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  mmp_pkg::t_in  i_in,
    input  logic          i_valid,
    input  mmp_pkg::t_out i_res,
    output int            o_errors,
    output int            o_pending
);
    import mmp_pkg::*;

    // Entries in row-major order: r0c0, r0c1, r1c0, r1c1.
    typedef bit [3:0][63:0] t_mat;

    localparam bit [63:0] PRIME = {34'd0, MOD_P};

    t_out expected_mats[$];
    int   mismatches = 0;
    int   pending    = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending;

    function automatic t_mat mat_mul_mod(input t_mat x, input t_mat y);
        t_mat r;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                r[2*i+j] = ((x[2*i] * y[j]) % PRIME + (x[2*i+1] * y[2+j]) % PRIME) % PRIME;
            end
        end
        return r;
    endfunction

    function automatic t_out mat_pow_mod(input t_in it);
        t_mat             base;
        t_mat             acc;
        bit [POW_W-1:0]   e;
        t_out             r;
        // Reduce unreduced entries on entry.
        base[0] = {34'd0, it.base_r0c0} % PRIME;
        base[1] = {34'd0, it.base_r0c1} % PRIME;
        base[2] = {34'd0, it.base_r1c0} % PRIME;
        base[3] = {34'd0, it.base_r1c1} % PRIME;
        acc    = '0;
        acc[0] = 64'd1;
        acc[3] = 64'd1;
        e = it.power;
        while (e != '0) begin
            if (e[0]) begin
                acc = mat_mul_mod(acc, base);
            end
            base = mat_mul_mod(base, base);
            e = e >> 1;
        end
        r.res_r0c0 = acc[0][ELEM_W-1:0];
        r.res_r0c1 = acc[1][ELEM_W-1:0];
        r.res_r1c0 = acc[2][ELEM_W-1:0];
        r.res_r1c1 = acc[3][ELEM_W-1:0];
        return r;
    endfunction

    task automatic check_elem(input string name, input t_elem want, input t_elem got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (i_rst_n) begin
            // Retire the result before queueing a transfer taken at the same edge.
            if (i_valid) begin
                if (expected_mats.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, i_res);
                    mismatches++;
                end else begin
                    want = expected_mats.pop_front();
                    check_elem("res_r0c0", want.res_r0c0, i_res.res_r0c0);
                    check_elem("res_r0c1", want.res_r0c1, i_res.res_r0c1);
                    check_elem("res_r1c0", want.res_r1c0, i_res.res_r1c0);
                    check_elem("res_r1c1", want.res_r1c1, i_res.res_r1c1);
                end
            end
            if (i_start && !i_busy) begin
                expected_mats.push_back(mat_pow_mod(i_in));
            end
        end
        pending <= expected_mats.size();
    end

endmodule

// ===== tb/sv/modular_matrix_power_2x2_tb.sv =====
// Testbench top for the 2x2 modular matrix power block: stimulus, watchdog and verdict.
module modular_matrix_power_2x2_tb;
    import mmp_pkg::*;

    localparam int RAND_ITEMS  = 580;
    localparam int IDLE_LIMIT  = 40000;
    localparam int TAIL_CYCLES = 200;

    localparam t_elem            ELEM_MAX = '1;
    localparam logic [POW_W-1:0] POW_MAX  = '1;
    localparam t_elem            P_M1     = t_elem'(MOD_P - 1);
    localparam t_elem            P_M2     = t_elem'(MOD_P - 2);
    localparam t_elem            P_P1     = t_elem'(MOD_P + 1);

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    t_in   i_in;
    logic  o_busy;
    logic  o_valid;
    t_out  o_res;

    int errors;
    int pending;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    modular_matrix_power_2x2 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    modular_matrix_power_2x2_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_busy    (o_busy),
        .i_in      (i_in),
        .i_valid   (o_valid),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Count cycles with no transfer in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    function automatic t_elem rand_elem();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
            return t_elem'($urandom_range(MOD_P - 1, 0));
        end else if (pick < 70) begin
            case ($urandom_range(3, 0))
                0:       return t_elem'(0);
                1:       return t_elem'(1);
                2:       return P_M1;
                default: return P_M2;
            endcase
        end else if (pick < 85) begin
            // Unreduced entry: at or above the prime.
            return t_elem'($urandom_range(ELEM_MAX, MOD_P));
        end else begin
            return t_elem'($urandom);
        end
    endfunction

    // Keep most exponents short; latency grows with their bit length.
    function automatic logic [POW_W-1:0] rand_power();
        int unsigned pick;
        int unsigned len;
        logic [63:0] raw;
        pick = $urandom_range(99, 0);
        raw  = {$urandom, $urandom};
        if (pick < 85) begin
            len = $urandom_range(12, 0);
        end else if (pick < 95) begin
            len = $urandom_range(30, 13);
        end else begin
            len = POW_W;
        end
        if (len == 0) begin
            return '0;
        end
        if (len < POW_W) begin
            raw = raw & ((64'd1 << len) - 64'd1);
            raw[len-1] = 1'b1;
        end
        return raw[POW_W-1:0];
    endfunction

    function automatic int pick_gap();
        int unsigned pick;
        if (no_gaps) begin
            return 0;
        end
        pick = $urandom_range(99, 0);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(4, 1);
        end else if (pick < 98) begin
            return $urandom_range(40, 5);
        end else begin
            return $urandom_range(300, 100);
        end
    endfunction

    // Entered and left at a falling edge; returns after the transfer.
    task automatic drive_item(input t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_mat(input t_elem b00, input t_elem b01, input t_elem b10,
                            input t_elem b11, input logic [POW_W-1:0] pw);
        t_in it;
        it.base_r0c0 = b00;
        it.base_r0c1 = b01;
        it.base_r1c0 = b10;
        it.base_r1c1 = b11;
        it.power     = pw;
        drive_item(it);
    endtask

    // Hold off until every outstanding result has come back.
    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_in it;
        i_start = 1'b0;
        i_in    = '0;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_mat(0, 0, 0, 0, 0);
        send_mat(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 0);
        send_mat(1, 0, 0, 1, POW_MAX);
        send_mat(1, 1, 1, 0, 1);
        send_mat(1, 1, 1, 0, 10);
        send_mat(1, 1, 1, 0, 90);
        send_mat(P_M1, P_M1, P_M1, P_M1, 1);
        send_mat(P_M1, P_M1, P_M1, P_M1, 2);
        send_mat(P_M1, P_M1, P_M1, P_M1, POW_MAX);
        send_mat(MOD_P, P_P1, ELEM_MAX, 2, 1);
        send_mat(MOD_P, P_P1, ELEM_MAX, 2, 3);
        send_mat(0, 0, 0, 0, 1);
        send_mat(0, 0, 0, 0, 5);
        send_mat(0, 1, 1, 0, 2);
        send_mat(2, 3, 5, 7, 63'h4000_0000_0000_0000);
        send_mat(123456789, 987654321, P_M2, 1, 63'h5555_5555_5555_5555);
        send_mat(ELEM_MAX, 0, 0, ELEM_MAX, 63'h2AAA_AAAA_AAAA_AAAA);
        send_mat(P_M1, 0, 0, P_M1, POW_MAX - 1);
        drain();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Switch between gapped and back-to-back stretches.
            if (n % 40 == 0) begin
                no_gaps = ($urandom_range(3, 0) == 0);
            end
            if (n == RAND_ITEMS / 2 || $urandom_range(49, 0) == 0) begin
                drain();
            end
            it.base_r0c0 = rand_elem();
            it.base_r0c1 = rand_elem();
            it.base_r1c0 = rand_elem();
            it.base_r1c1 = rand_elem();
            it.power     = rand_power();
            drive_item(it);
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
